// ===== rtl/pai_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_pkg
// Shared constants, types and codes of the antichain insertion block.
// ----------------------------------------------------------------------------
package pai_pkg;

  localparam int CAPACITY      = 16;
  localparam int MAX_FRAGMENTS = 8;
  localparam int VALUE_WIDTH   = 32;

  // One spare cell: an insert may land before erasures of later entries.
  localparam int CHAIN_LEN = CAPACITY + 1;
  localparam int LEN_W     = $clog2(CHAIN_LEN + 1);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic CFG_FRAGMENT_COUNT = 1'b0;
  localparam logic CFG_PLAIN_MASK     = 1'b1;

  typedef logic [MAX_FRAGMENTS-1:0][VALUE_WIDTH-1:0] entry_t;

  typedef struct packed {
    logic take_next;
    logic take_head;
    logic take_cand;
  } cell_ctl_t;

  typedef struct packed {
    logic smaller;  // candidate below entry in some fragment, no plain mismatch
    logic larger;   // candidate above entry in some fragment, no plain mismatch
    logic exceeds;  // entry above candidate in a fragment seen before any mismatch
  } cmp_t;

endpackage

// ===== rtl/pai_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_cell
// One bucket slot: holds an entry, or takes its neighbor, the head or the
// candidate.
// ----------------------------------------------------------------------------
module pai_cell (
  input  logic                clk,
  input  pai_pkg::cell_ctl_t  ctl,
  input  pai_pkg::entry_t     next_entry,
  input  pai_pkg::entry_t     head_entry,
  input  pai_pkg::entry_t     cand_entry,
  output pai_pkg::entry_t     entry
);

  always_ff @(posedge clk) begin
    if (ctl.take_cand) begin
      entry <= cand_entry;
    end else if (ctl.take_head) begin
      entry <= head_entry;
    end else if (ctl.take_next) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== rtl/pai_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_cmp
// Fragment-wise dominance compare of the candidate against the head entry.
// ----------------------------------------------------------------------------
module pai_cmp (
  input  pai_pkg::entry_t                        cand,
  input  pai_pkg::entry_t                        entry,
  input  logic [3:0]                             count,
  input  logic [pai_pkg::MAX_FRAGMENTS-1:0]      mask,
  output pai_pkg::cmp_t                          res
);

  always_comb begin
    logic lt;
    logic gt;
    logic broke;
    lt    = 1'b0;
    gt    = 1'b0;
    broke = 1'b0;
    for (int f = 0; f < pai_pkg::MAX_FRAGMENTS; f++) begin
      if (f < int'(count) && !broke) begin
        if (mask[f]) begin
          // plain fragment: any difference ends the compare
          if (cand[f] != entry[f]) broke = 1'b1;
        end else if ($signed(cand[f]) < $signed(entry[f])) begin
          lt = 1'b1;
        end else if ($signed(cand[f]) > $signed(entry[f])) begin
          gt = 1'b1;
        end
      end
    end
    res.smaller = lt && !broke;
    res.larger  = gt && !broke;
    res.exceeds = lt;
  end

endmodule

// ===== rtl/pareto_antichain_insert_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_antichain_insert_top
// Ordered bucket of up to sixteen vectors kept as a Pareto antichain.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: op, value, entry_index, fragment_index are taken at an
//   edge with start high and busy low. Op push loads one candidate fragment;
//   the push that completes the candidate starts an insert. Op read returns
//   one stored fragment, op clear empties the bucket.
//   Result channel: done strobes for one cycle with kind and the outcome
//   fields; the receiver cannot hold a beat off, so take it when it shows.
//   Config port: cfg_we/cfg_index/cfg_data write fragment_count (index 0)
//   or plain_mask (index 1) with no wait; write only while idle.
// Sequencing:
//   Read and clear strobe done in the cycle after the beat; a partial push
//   gives no beat. Busy stays low for all three.
//   During an insert busy stays high: the scan state rotates the cell chain
//   through the comparator at the head (one entry a cycle) to mark erasures,
//   then the build state rebuilds the order (one step per kept or dropped
//   entry, one for the candidate when it goes in, one to close).
//   done rises as busy falls.
// Reset: bucket empty, no fragments loaded, fragment_count 1, mask 0.
// ----------------------------------------------------------------------------
module pareto_antichain_insert_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic signed [31:0]  value,
  input  logic [3:0]          entry_index,
  input  logic [2:0]          fragment_index,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                done,
  output logic [1:0]          kind,
  output logic                inserted,
  output logic [4:0]          removed_count,
  output logic                overflow,
  output logic [4:0]          entry_count,
  output logic signed [31:0]  read_value,
  output logic                read_valid
);

  localparam int CAP   = pai_pkg::CAPACITY;
  localparam int CHAIN = pai_pkg::CHAIN_LEN;
  localparam int MAXF  = pai_pkg::MAX_FRAGMENTS;
  localparam int LEN_W = pai_pkg::LEN_W;
  localparam int CNT_W = pai_pkg::CNT_W;
  localparam int IDX_W = pai_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_BUILD = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_KEEP,
    ACT_DROP,
    ACT_INS
  } act_t;

  state_t state;
  act_t   act;

  logic [3:0]       fragment_count;
  logic [MAXF-1:0]  plain_mask;
  logic [3:0]       cnt_eff;

  pai_pkg::entry_t  cand_buf;
  pai_pkg::entry_t  cand_entry;
  logic [3:0]       loaded;
  logic [4:0]       loaded_next;

  pai_pkg::entry_t  cell_q [CHAIN];
  pai_pkg::cmp_t    cmp_res;

  logic [CNT_W-1:0] stored_entries;
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] kept;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] wr;
  logic [CNT_W-1:0] rem;
  logic             found;
  logic             rejected;
  logic             ins_pending;
  logic             ins_flag;
  logic             ovf_flag;
  logic [CAP-1:0]   drop;

  logic             accept;
  logic             step_live;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign step_live = (step < stored_entries);

  // Clamp the fragment count into 1..MAX_FRAGMENTS.
  always_comb begin
    if (fragment_count == 4'd0) begin
      cnt_eff = 4'd1;
    end else if (int'(fragment_count) > MAXF) begin
      cnt_eff = 4'(MAXF);
    end else begin
      cnt_eff = fragment_count;
    end
  end

  // Zero the fragments at or above the count before storing.
  always_comb begin
    for (int f = 0; f < MAXF; f++) begin
      cand_entry[f] = (f < int'(cnt_eff)) ? cand_buf[f] : '0;
    end
  end

  assign loaded_next = {1'b0, loaded} + 5'd1;

  pai_cmp u_cmp (
    .cand  (cand_buf),
    .entry (cell_q[0]),
    .count (cnt_eff),
    .mask  (plain_mask),
    .res   (cmp_res)
  );

  // Chain action for this cycle.
  always_comb begin
    act = ACT_HOLD;
    case (state)
      ST_SCAN: begin
        if (step_live) act = ACT_KEEP;
      end
      ST_BUILD: begin
        if (ins_pending && wr == pos) begin
          act = ACT_INS;
        end else if (step_live) begin
          act = drop[step[IDX_W-1:0]] ? ACT_DROP : ACT_KEEP;
        end
      end
      default: act = ACT_HOLD;
    endcase
  end

  // Cell row: occupied cells shift toward the head; the head wraps to the
  // tail on keep, falls away on drop; insert lands just past the tail.
  for (genvar k = 0; k < CHAIN; k++) begin : g_cell
    pai_pkg::cell_ctl_t ctl;
    pai_pkg::entry_t    nxt;
    if (k + 1 < CHAIN) begin : g_nxt
      assign nxt = cell_q[k+1];
    end else begin : g_last
      assign nxt = '0;
    end
    assign ctl.take_next = (act == ACT_KEEP || act == ACT_DROP) && (LEN_W'(k + 1) < len);
    assign ctl.take_head = (act == ACT_KEEP) && (LEN_W'(k + 1) == len);
    assign ctl.take_cand = (act == ACT_INS) && (LEN_W'(k) == len);
    pai_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .next_entry (nxt),
      .head_entry (cell_q[0]),
      .cand_entry (cand_entry),
      .entry      (cell_q[k])
    );
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_count <= 4'd1;
      plain_mask     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pai_pkg::CFG_FRAGMENT_COUNT: fragment_count <= cfg_data[3:0];
        pai_pkg::CFG_PLAIN_MASK:     plain_mask     <= cfg_data[MAXF-1:0];
        default: ;
      endcase
    end
  end

  // Candidate buffer: payload, no reset.
  always_ff @(posedge clk) begin
    if (accept && op == pai_pkg::OP_PUSH && int'(loaded) < MAXF) begin
      cand_buf[loaded[2:0]] <= value;
    end
  end

  // Scan bookkeeping: payload, held cleared while idle, so it starts clear when an insert starts.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      step     <= '0;
      kept     <= '0;
      pos      <= '0;
      wr       <= '0;
      rem      <= '0;
      found    <= 1'b0;
      rejected <= 1'b0;
      drop     <= '0;
    end else if (state == ST_SCAN) begin
      if (step_live) begin
        step <= step + 1'b1;
        if (!rejected && cmp_res.exceeds && !found) begin
          pos   <= kept;
          found <= 1'b1;
        end
        if (!rejected && cmp_res.larger && !cmp_res.smaller) begin
          // dominated: erase
          drop[step[IDX_W-1:0]] <= 1'b1;
          rem <= rem + 1'b1;
        end else begin
          if (!rejected && cmp_res.smaller && !cmp_res.larger) rejected <= 1'b1;
          kept <= kept + 1'b1;
        end
      end else begin
        step <= '0;
        if (!found) pos <= kept;
      end
    end else begin
      case (act)
        ACT_INS:  wr <= wr + 1'b1;
        ACT_KEEP: begin
          wr   <= wr + 1'b1;
          step <= step + 1'b1;
        end
        ACT_DROP: step <= step + 1'b1;
        default: ;
      endcase
    end
  end

  // Control: state, fill levels, result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      loaded         <= '0;
      stored_entries <= '0;
      len            <= '0;
      ins_pending    <= 1'b0;
      ins_flag       <= 1'b0;
      ovf_flag       <= 1'b0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (act)
        ACT_DROP: len <= len - 1'b1;
        ACT_INS:  len <= len + 1'b1;
        default: ;
      endcase
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              pai_pkg::OP_PUSH: begin
                if (loaded_next >= {1'b0, cnt_eff}) begin
                  loaded <= '0;
                  len    <= LEN_W'(stored_entries);
                  state  <= ST_SCAN;
                end else begin
                  loaded <= loaded_next[3:0];
                end
              end
              pai_pkg::OP_READ: done <= 1'b1;
              pai_pkg::OP_CLEAR: begin
                stored_entries <= '0;
                done           <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (!step_live) begin
            ins_pending <= !rejected && (int'(kept) < CAP);
            ins_flag    <= !rejected && (int'(kept) < CAP);
            ovf_flag    <= !rejected && (int'(kept) >= CAP);
            state       <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          if (act == ACT_INS) ins_pending <= 1'b0;
          if (act == ACT_HOLD) begin
            stored_entries <= len[CNT_W-1:0];
            done           <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result fields: payload, valid while done is high.
  always_ff @(posedge clk) begin
    if (state == ST_BUILD && act == ACT_HOLD) begin
      kind          <= pai_pkg::KIND_INSERT;
      inserted      <= ins_flag;
      removed_count <= rem;
      overflow      <= ovf_flag;
      entry_count   <= len[CNT_W-1:0];
      read_value    <= '0;
      read_valid    <= 1'b0;
    end else if (accept && op == pai_pkg::OP_READ) begin
      kind          <= pai_pkg::KIND_READ;
      inserted      <= 1'b0;
      removed_count <= '0;
      overflow      <= 1'b0;
      entry_count   <= stored_entries;
      if ({1'b0, entry_index} < stored_entries) begin
        read_value <= cell_q[{1'b0, entry_index}][fragment_index];
        read_valid <= 1'b1;
      end else begin
        read_value <= '0;
        read_valid <= 1'b0;
      end
    end else if (accept && op == pai_pkg::OP_CLEAR) begin
      kind          <= pai_pkg::KIND_CLEAR;
      inserted      <= 1'b0;
      removed_count <= '0;
      overflow      <= 1'b0;
      entry_count   <= '0;
      read_value    <= '0;
      read_valid    <= 1'b0;
    end
  end

  // Checks.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(stored_entries) <= CAP)
    else $error("bucket holds more than its capacity");

  a_ins_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(inserted && overflow))
    else $error("insert reported both stored and dropped");

  a_read_only_valid: assert property (@(posedge clk) disable iff (rst)
    (done && kind != pai_pkg::KIND_READ) |-> !read_valid)
    else $error("read_valid on a non-read beat");

  a_chain_bound: assert property (@(posedge clk) disable iff (rst)
    int'(len) <= CHAIN)
    else $error("cell chain over-filled");

endmodule
